// File: design/rwm_pkg.sv
// Package for the rolling window mean filter.
// Holds register codes, fixed field widths and the controller/datapath structs.
// No dependencies.
package rwm_pkg;

	localparam int WEIGHT_BITS   = 20;
	localparam int OUT_BITS      = 24;
	localparam int WL_BITS       = 7;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam logic [WL_BITS-1:0] WL_RESET = 7'd30;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_SKIP_MISSING  = 2'd1,
		REG_EXP_WEIGHTED  = 2'd2
	} rwm_reg_t;

	typedef struct packed {
		logic store;
		logic scan_issue;
		logic pass_init;
		logic rd2;
		logic mac;
		logic upd;
		logic div_init;
		logic div_step;
		logic res_zero;
		logic res_miss;
		logic res_div;
		logic out_load;
	} rwm_cmd_t;

	typedef struct packed {
		logic full;
		logic scan_last;
		logic poisoned;
		logic none_present;
		logic k_done;
		logic rd_miss;
		logic div_busy;
	} rwm_sts_t;

endpackage

// File: design/rwm_if.sv
// Channel interfaces of the rolling window mean filter: sample input,
// result output and configuration write. Depends on rwm_pkg.
interface rwm_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          sample_missing;
	modport source (output valid, output sample, output sample_missing, input ready);
	modport sink (input valid, input sample, input sample_missing, output ready);
endinterface

interface rwm_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rwm_pkg::OUT_BITS-1:0] mean_value;
	logic                                window_full;
	logic                                mean_missing;
	modport source (output valid, output mean_value, output window_full,
		output mean_missing, input ready);
	modport sink (input valid, input mean_value, input window_full,
		input mean_missing, output ready);
endinterface

interface rwm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rwm_pkg::CFG_IDX_BITS-1:0]   index;
	logic [rwm_pkg::CFG_DATA_BITS-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/rwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwm_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/rwm_ctrl.sv
// Controller state machine of the rolling window mean filter.
// Drives datapath commands from its status; depends on rwm_pkg.
module rwm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rwm_pkg::rwm_sts_t sts,
	output rwm_pkg::rwm_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_STORE, S_SCAN, S_SCAN_END, S_CHECK, S_RD, S_AC, S_UP,
		S_DIV_INIT, S_DIV, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.store = 1'b1;
					state_d   = S_STORE;
				end
			end
			S_STORE: begin
				if (!sts.full) begin
					cmd.res_zero = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_CHECK;
			S_CHECK: begin
				if (sts.poisoned || sts.none_present) begin
					cmd.res_miss = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.pass_init = 1'b1;
					state_d       = S_RD;
				end
			end
			S_RD: begin
				cmd.rd2 = 1'b1;
				state_d = S_AC;
			end
			S_AC: begin
				if (sts.rd_miss) begin
					state_d = sts.k_done ? S_DIV_INIT : S_RD;
				end else begin
					cmd.mac = 1'b1;
					state_d = S_UP;
				end
			end
			S_UP: begin
				cmd.upd = 1'b1;
				state_d = sts.k_done ? S_DIV_INIT : S_RD;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				if (sts.div_busy) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.res_div = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// A new result must never overwrite one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending result");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("output valid rose without a result load");

	a_store_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (in_valid && in_ready))
		else $error("sample stored without an input transaction");
endmodule

// File: design/rwm_dp.sv
// Datapath of the rolling window mean filter: sample ring, window scan,
// weighted accumulate, weight recurrence and bit-serial rounding divider.
// Depends on rwm_pkg and rwm_ram.
module rwm_dp #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [rwm_pkg::WL_BITS-1:0]          window_length,
	input  logic                                 skip_missing,
	input  logic                                 exp_weighted,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 sample_missing,
	input  rwm_pkg::rwm_cmd_t                    cmd,
	output rwm_pkg::rwm_sts_t                    sts,
	output logic signed [rwm_pkg::OUT_BITS-1:0]  mean_value,
	output logic                                 window_full,
	output logic                                 mean_missing
);
	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int CW   = $clog2(WINDOW_MAX + 1);
	localparam int UW   = rwm_pkg::WEIGHT_BITS + 1;
	localparam int XUW  = SAMPLE_BITS + UW + 1;
	localparam int ACCW = XUW + CW;
	localparam int DENW = UW + CW;
	localparam int NB   = UW + CW;
	localparam int DB   = $clog2(WINDOW_MAX + 2);
	localparam int KB   = NB + DB;
	localparam int NUMW = ACCW + FRAC_BITS + 2;
	localparam int DVW  = DENW + 1;
	localparam int DCW  = $clog2(NUMW + 1);
	localparam int CMPW = (CW > rwm_pkg::WL_BITS) ? CW : rwm_pkg::WL_BITS;
	localparam int OB   = rwm_pkg::OUT_BITS;
	localparam int RW   = SAMPLE_BITS + 1;

	// Reciprocals ceil(2^KB / d) for d = present + 1, exact for every product.
	logic [KB-1:0] rcp_tab [WINDOW_MAX];
	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_rcp
		localparam longint unsigned Den = longint'(g) + 64'd2;
		localparam longint unsigned RCP = ((64'd1 << KB) + Den - 64'd1) / Den;
		assign rcp_tab[g] = KB'(RCP);
	end

	logic [AW-1:0]             wp_q, newest_q, ptr_q;
	logic [CW-1:0]             fill_q, w_eff_q, k_q, present_q, pm1_q;
	logic                      any_miss_q, eval_s1;
	logic [RW-1:0]             rdata;
	logic signed [SAMPLE_BITS-1:0] rd_sample;
	logic                      rd_miss;
	logic [UW-1:0]             u_q;
	logic [KB-1:0]             rcp_q;
	logic signed [XUW-1:0]     xu_s1;
	logic [NB-1:0]             nprod_s1;
	logic [NB+KB-1:0]          qprod;
	logic signed [ACCW-1:0]    acc_q;
	logic [DENW-1:0]           den_q;
	logic [ACCW-1:0]           mag;
	logic [NUMW-1:0]           num_q, quo_q;
	logic [DVW-1:0]            dvs_q, rem_q;
	logic [DVW:0]              trial;
	logic                      ge;
	logic [DCW-1:0]            div_cnt_q;
	logic                      neg_q;
	logic [CMPW-1:0]           wl_ext;
	logic [CW-1:0]             w_clamp;
	logic signed [OB-1:0]      div_mean;
	logic [NUMW-1:0]           lim;
	logic signed [OB-1:0]      res_mean_q;
	logic                      res_full_q, res_miss_q;
	logic [AW-1:0]             wp_next, ptr_next;

	rwm_ram #(.WIDTH(RW), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (wp_q),
		.wdata ({sample_missing, sample}),
		.re    (cmd.scan_issue | cmd.rd2),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	assign rd_sample = rdata[SAMPLE_BITS-1:0];
	assign rd_miss   = rdata[SAMPLE_BITS];
	assign wp_next   = (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
	assign ptr_next  = (ptr_q == '0) ? AW'(WINDOW_MAX - 1) : ptr_q - 1'b1;

	always_comb begin
		wl_ext = CMPW'(window_length);
		if (window_length == '0) begin
			w_clamp = CW'(1);
		end else if (wl_ext > CMPW'(WINDOW_MAX)) begin
			w_clamp = CW'(WINDOW_MAX);
		end else begin
			w_clamp = wl_ext[CW-1:0];
		end
	end

	assign qprod = (NB + KB)'(nprod_s1) * (NB + KB)'(rcp_q);
	assign mag   = acc_q[ACCW-1] ? ACCW'(-acc_q) : ACCW'(acc_q);
	assign trial = {rem_q, num_q[NUMW-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign lim   = NUMW'(1) << (OB - 1);

	always_comb begin
		if (neg_q) begin
			div_mean = (quo_q > lim) ? {1'b1, {(OB - 1){1'b0}}} : -quo_q[OB-1:0];
		end else begin
			div_mean = (quo_q > lim - 1'b1) ? {1'b0, {(OB - 1){1'b1}}} : quo_q[OB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			fill_q     <= '0;
			w_eff_q    <= CW'(1);
			k_q        <= '0;
			present_q  <= '0;
			any_miss_q <= 1'b0;
			eval_s1    <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			eval_s1 <= cmd.scan_issue;
			if (cmd.store) begin
				wp_q       <= wp_next;
				w_eff_q    <= w_clamp;
				k_q        <= '0;
				present_q  <= '0;
				any_miss_q <= 1'b0;
				if (fill_q != CW'(WINDOW_MAX)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.pass_init) begin
				k_q <= '0;
			end
			if (cmd.scan_issue || cmd.rd2) begin
				k_q <= k_q + 1'b1;
			end
			if (eval_s1) begin
				if (rd_miss) begin
					any_miss_q <= 1'b1;
				end else begin
					present_q <= present_q + 1'b1;
				end
			end
			if (cmd.div_init) begin
				div_cnt_q <= DCW'(NUMW);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			newest_q <= wp_q;
			ptr_q    <= wp_q;
		end
		if (cmd.scan_issue || cmd.rd2) begin
			ptr_q <= ptr_next;
		end
		if (cmd.pass_init) begin
			ptr_q <= newest_q;
			acc_q <= '0;
			den_q <= '0;
			u_q   <= exp_weighted ? UW'(1) << rwm_pkg::WEIGHT_BITS : UW'(1);
			pm1_q <= present_q - 1'b1;
			rcp_q <= rcp_tab[AW'(present_q - 1'b1)];
		end
		if (cmd.mac) begin
			xu_s1    <= rd_sample * $signed({1'b0, u_q});
			nprod_s1 <= NB'(u_q) * NB'(pm1_q);
			den_q    <= den_q + DENW'(u_q);
		end
		if (cmd.upd) begin
			acc_q <= acc_q + ACCW'(xu_s1);
			if (exp_weighted) begin
				u_q <= qprod[KB +: UW];
			end
		end
		if (cmd.div_init) begin
			neg_q <= acc_q[ACCW-1];
			num_q <= (NUMW'(mag) << (FRAC_BITS + 1)) + NUMW'(den_q);
			dvs_q <= {den_q, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? DVW'(trial - {1'b0, dvs_q}) : trial[DVW-1:0];
			quo_q <= {quo_q[NUMW-2:0], ge};
			num_q <= num_q << 1;
		end
		if (cmd.res_zero) begin
			res_mean_q <= '0;
			res_full_q <= 1'b0;
			res_miss_q <= 1'b0;
		end
		if (cmd.res_miss) begin
			res_mean_q <= '0;
			res_full_q <= 1'b1;
			res_miss_q <= 1'b1;
		end
		if (cmd.res_div) begin
			res_mean_q <= div_mean;
			res_full_q <= 1'b1;
			res_miss_q <= 1'b0;
		end
		if (cmd.out_load) begin
			mean_value   <= res_mean_q;
			window_full  <= res_full_q;
			mean_missing <= res_miss_q;
		end
	end

	assign sts.full         = (fill_q >= w_eff_q);
	assign sts.scan_last    = (k_q == w_eff_q - 1'b1);
	assign sts.poisoned     = any_miss_q && !skip_missing;
	assign sts.none_present = (present_q == '0);
	assign sts.k_done       = (k_q == w_eff_q);
	assign sts.rd_miss      = rd_miss;
	assign sts.div_busy     = (div_cnt_q != '0);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_MAX))
		else $error("fill count beyond ring depth");

	a_present_bound: assert property (@(posedge clk) disable iff (!arst_n)
		present_q <= w_eff_q)
		else $error("present count exceeds window length");

	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (div_cnt_q != '0))
		else $error("divider stepped after its last quotient bit");
endmodule

// File: design/rolling_window_mean_filter.sv
// Rolling window mean filter: one result per sample, computed over a window of w entries.
// Once the window is full, the processing time is set by the ring scan, the read/multiply/update
// step per entry and the 55-step bit-serial divider. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
// Reset clears the control state and the configuration registers; ring contents are kept.
module rolling_window_mean_filter #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input logic       clk,
	input logic       arst_n,
	rwm_in_if.sink    in_ch,
	rwm_out_if.source out_ch,
	rwm_cfg_if.sink   cfg
);
	logic [rwm_pkg::WL_BITS-1:0] window_length_q;
	logic                        skip_missing_q;
	logic                        exp_weighted_q;
	rwm_pkg::rwm_cmd_t           cmd;
	rwm_pkg::rwm_sts_t           sts;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= rwm_pkg::WL_RESET;
			skip_missing_q  <= 1'b0;
			exp_weighted_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (rwm_pkg::rwm_reg_t'(cfg.index))
				rwm_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg.data[rwm_pkg::WL_BITS-1:0];
				rwm_pkg::REG_SKIP_MISSING:  skip_missing_q  <= cfg.data[0];
				rwm_pkg::REG_EXP_WEIGHTED:  exp_weighted_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	rwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rwm_dp #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_length  (window_length_q),
		.skip_missing   (skip_missing_q),
		.exp_weighted   (exp_weighted_q),
		.sample         (in_ch.sample),
		.sample_missing (in_ch.sample_missing),
		.cmd            (cmd),
		.sts            (sts),
		.mean_value     (out_ch.mean_value),
		.window_full    (out_ch.window_full),
		.mean_missing   (out_ch.mean_missing)
	);
endmodule
